### rtl/fpw_pkg.sv
`timescale 1ns / 1ps
package fpw_pkg;

  localparam int FRAMES_DEF        = 64;
  localparam int TLB_SIZE_DEF      = 16;
  localparam int TABLE_ENTRIES     = 512;
  localparam int PAGE_SHIFT        = 12;
  localparam int IDX_W             = 9;
  localparam int FRAME_W           = 6;
  localparam int FRAME_LIMIT       = 64;
  localparam int VPN_W             = 36;
  localparam int ENTRY_W           = 7;

  localparam logic [1:0] OP_TRANSLATE = 2'd0;
  localparam logic [1:0] OP_MAP       = 2'd1;
  localparam logic [1:0] OP_ALLOC     = 2'd2;
  localparam logic [1:0] OP_UNMAP     = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNMAPPED = 2'd1;
  localparam logic [1:0] ST_NOFRAME  = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [47:0]        virt_addr;
    logic [FRAME_W-1:0] phys_frame;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               tlb_hit;
    logic               present;
    logic [FRAME_W-1:0] frame_out;
  } rsp_t;

  // Request from the sequencer to the frame allocator and its answer.
  typedef struct packed {
    logic               start;
    logic               clr;
    logic [FRAME_W-1:0] clr_frame;
  } alloc_cmd_t;

  typedef struct packed {
    logic               done;
    logic               found;
    logic [FRAME_W-1:0] frame;
  } alloc_rsp_t;

endpackage

### rtl/fpw_alloc.sv
`timescale 1ns / 1ps
// Lowest-free frame search, one frame tested per cycle, with the used bitmap.
module fpw_alloc #(
  parameter int FRAMES = fpw_pkg::FRAMES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fpw_pkg::alloc_cmd_t cmd_i,
  output fpw_pkg::alloc_rsp_t rsp_o
);
  import fpw_pkg::*;

  localparam int SPAN = (FRAMES < FRAME_LIMIT) ? FRAMES : FRAME_LIMIT;

  logic [FRAMES-1:0]  used_q, used_d;
  logic               busy_q, busy_d;
  logic [FRAME_W-1:0] idx_q, idx_d;
  logic               cur_used;

  assign cur_used = used_q[idx_q];

  always_comb begin
    used_d = used_q;
    busy_d = busy_q;
    idx_d  = idx_q;
    rsp_o  = '0;
    if (cmd_i.clr && (32'(cmd_i.clr_frame) < FRAMES)) begin
      used_d[cmd_i.clr_frame] = 1'b0;
    end
    if (cmd_i.start) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (busy_q) begin
      // Test one frame per cycle; the first free one wins.
      if (!cur_used) begin
        rsp_o.done  = 1'b1;
        rsp_o.found = 1'b1;
        rsp_o.frame = idx_q;
        used_d[idx_q] = 1'b1;
        busy_d = 1'b0;
      end else if (32'(idx_q) == SPAN - 1) begin
        rsp_o.done = 1'b1;
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      used_q <= used_d;
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

endmodule

### rtl/four_level_page_walk_tlb_unit.sv
`timescale 1ns / 1ps
// Four-level page walk unit with a direct-mapped TLB.
// Input channel in_valid_i / in_stall_o carries one request item (opcode,
// virtual address, frame); output channel out_valid_o / out_stall_i carries
// one response item per request. in_stall_o is high while an item is in work.
// Steps per item: a TLB hit goes through accept, lookup and response. A
// walk reads the root from its own memory in the lookup state and takes a
// read state and a use state of the registered data per lower level on the
// table memory read port. Alloc searches up from frame 0 to the lowest
// free one, or through all SPAN frames when none is free. Map builds each
// missing level with an allocator search, a zeroing sweep over the 512
// entries of the new table and a link step. The rate is set by the table
// memory port and the allocator. After reset a clearing pass over the 512
// root entries zeroes the root table, with in_stall_o high; all frames are
// free and the TLB is empty. A table is zeroed when its frame becomes a
// table. When the receiver stalls, the response holds in the output
// register and no new item is accepted.
module four_level_page_walk_tlb_unit #(
  parameter int FRAMES   = fpw_pkg::FRAMES_DEF,
  parameter int TLB_SIZE = fpw_pkg::TLB_SIZE_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  fpw_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output fpw_pkg::rsp_t out_data_o
);
  import fpw_pkg::*;

  localparam int TLB_W = (TLB_SIZE > 1) ? $clog2(TLB_SIZE) : 1;
  localparam int FR_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int MEM_W = FR_W + IDX_W;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_TLB   = 11'b00000000010,
    S_RDREQ = 11'b00000000100,
    S_RDUSE = 11'b00000001000,
    S_ALLOC = 11'b00000010000,
    S_ZERO  = 11'b00000100000,
    S_LEAF  = 11'b00001000000,
    S_AONLY = 11'b00010000000,
    S_RESP  = 11'b00100000000,
    S_LINK  = 11'b01000000000,
    S_CLEAR = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  req_t   req_q;
  rsp_t   rsp_q, rsp_d;
  logic [1:0]         lvl_q, lvl_d;
  logic [FRAME_W-1:0] tf_q, tf_d;
  logic [IDX_W-1:0]   zc_q, zc_d;
  logic [FRAME_W-1:0] nf_q, nf_d;
  logic [IDX_W-1:0]   clr_q, clr_d;

  // Root table memory with a registered read; table store memory.
  logic [ENTRY_W-1:0] root_q [TABLE_ENTRIES];
  logic [ENTRY_W-1:0] root_rd_q;
  logic [ENTRY_W-1:0] mem [FRAMES*TABLE_ENTRIES];
  logic [ENTRY_W-1:0] rd_q;
  logic               mem_re, mem_we, root_we;
  logic [MEM_W-1:0]   mem_ra, mem_wa;
  logic [IDX_W-1:0]   root_wa;
  logic [ENTRY_W-1:0] mem_wd, root_wd;

  logic [TLB_SIZE-1:0] tlb_v_q;
  logic [VPN_W-1:0]    tlb_tag_q [TLB_SIZE];
  logic [FRAME_W-1:0]  tlb_fr_q [TLB_SIZE];
  logic                tlb_fill, tlb_drop;

  alloc_cmd_t acmd;
  alloc_rsp_t arsp;

  logic [VPN_W-1:0]   vpn;
  logic [TLB_W-1:0]   ti;
  logic [IDX_W-1:0]   idx;
  logic [IDX_W-1:0]   ridx;
  logic [ENTRY_W-1:0] entry;
  logic               tlb_match;

  fpw_alloc #(.FRAMES(FRAMES)) u_alloc (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (acmd),
    .rsp_o (arsp)
  );

  assign vpn  = req_q.virt_addr[47:PAGE_SHIFT];
  assign ti   = (TLB_SIZE > 1) ? TLB_W'(vpn % TLB_SIZE) : '0;
  assign ridx = req_q.virt_addr[47:39];
  assign idx  = req_q.virt_addr[PAGE_SHIFT + IDX_W*lvl_q +: IDX_W];
  assign tlb_match = tlb_v_q[ti] && (tlb_tag_q[ti] == vpn);
  // Entry of the current level: registered root read or table memory read.
  assign entry = (lvl_q == 2'd3) ? root_rd_q : rd_q;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_RESP);
  assign out_data_o  = rsp_q;

  function automatic logic [MEM_W-1:0] maddr(logic [FRAME_W-1:0] f, logic [IDX_W-1:0] i);
    logic [FRAME_W-1:0] fm;
    fm = FRAME_W'(32'(f) % FRAMES);
    return {FR_W'(fm), i};
  endfunction

  always_comb begin
    state_d = state_q;
    rsp_d   = rsp_q;
    lvl_d   = lvl_q;
    tf_d    = tf_q;
    zc_d    = zc_q;
    nf_d    = nf_q;
    clr_d   = clr_q;
    mem_re  = 1'b0;
    mem_ra  = maddr(tf_q, idx);
    mem_we  = 1'b0;
    mem_wa  = maddr(tf_q, idx);
    mem_wd  = '0;
    root_we = 1'b0;
    root_wa = ridx;
    root_wd = '0;
    tlb_fill = 1'b0;
    tlb_drop = 1'b0;
    acmd    = '0;
    case (state_q)
      S_CLEAR: begin
        // Zero one root entry per cycle after reset.
        root_we = 1'b1;
        root_wa = clr_q;
        clr_d   = clr_q + 1'b1;
        if (clr_q == IDX_W'(TABLE_ENTRIES - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          rsp_d = '0;
          lvl_d = 2'd3;
          tf_d  = '0;
          if (in_data_i.opcode == OP_ALLOC) begin
            acmd.start = 1'b1;
            state_d = S_AONLY;
          end else begin
            state_d = S_TLB;
          end
        end
      end
      S_TLB: begin
        if (req_q.opcode == OP_TRANSLATE && tlb_match) begin
          rsp_d.tlb_hit = 1'b1;
          rsp_d.present = 1'b1;
          rsp_d.frame_out = tlb_fr_q[ti];
          state_d = S_RESP;
        end else begin
          state_d = S_RDUSE;
        end
      end
      S_RDREQ: begin
        mem_re  = 1'b1;
        state_d = S_RDUSE;
      end
      S_RDUSE: begin
        if (!entry[0] && lvl_q != 2'd0) begin
          if (req_q.opcode == OP_MAP) begin
            acmd.start = 1'b1;
            state_d = S_ALLOC;
          end else begin
            rsp_d.status = ST_UNMAPPED;
            if (req_q.opcode == OP_UNMAP) tlb_drop = tlb_match;
            state_d = S_RESP;
          end
        end else if (lvl_q == 2'd0) begin
          state_d = S_LEAF;
        end else begin
          tf_d  = entry[ENTRY_W-1:1];
          lvl_d = lvl_q - 2'd1;
          state_d = S_RDREQ;
        end
      end
      S_ALLOC: begin
        if (arsp.done) begin
          if (!arsp.found) begin
            rsp_d.status = ST_NOFRAME;
            state_d = S_RESP;
          end else begin
            nf_d = arsp.frame;
            zc_d = '0;
            state_d = S_ZERO;
          end
        end
      end
      S_ZERO: begin
        // Zero the new table, one entry per cycle.
        mem_we = 1'b1;
        mem_wa = maddr(nf_q, zc_q);
        zc_d   = zc_q + 1'b1;
        if (zc_q == IDX_W'(TABLE_ENTRIES - 1)) state_d = S_LINK;
      end
      S_LINK: begin
        // Link the new table into the parent entry.
        if (lvl_q == 2'd3) begin
          root_we = 1'b1;
          root_wd = {nf_q, 1'b1};
        end else begin
          mem_we = 1'b1;
          mem_wd = {nf_q, 1'b1};
        end
        tf_d  = nf_q;
        lvl_d = lvl_q - 2'd1;
        state_d = S_RDREQ;
      end
      S_LEAF: begin
        if (req_q.opcode == OP_MAP) begin
          mem_we = 1'b1;
          mem_wd = {req_q.phys_frame, 1'b1};
          tlb_fill = 1'b1;
          rsp_d.present = 1'b1;
          rsp_d.frame_out = req_q.phys_frame;
        end else if (req_q.opcode == OP_UNMAP) begin
          tlb_drop = tlb_match;
          if (entry[0]) begin
            mem_we = 1'b1;
            acmd.clr = 1'b1;
            acmd.clr_frame = entry[ENTRY_W-1:1];
            rsp_d.frame_out = entry[ENTRY_W-1:1];
          end else begin
            rsp_d.status = ST_UNMAPPED;
          end
        end else begin
          if (entry[0]) begin
            rsp_d.present = 1'b1;
            rsp_d.frame_out = entry[ENTRY_W-1:1];
          end else begin
            rsp_d.status = ST_UNMAPPED;
          end
        end
        state_d = S_RESP;
      end
      S_AONLY: begin
        if (arsp.done) begin
          if (arsp.found) rsp_d.frame_out = arsp.frame;
          else rsp_d.status = ST_NOFRAME;
          state_d = S_RESP;
        end
      end
      S_RESP: begin
        if (!out_stall_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Memories, request and datapath registers.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_q <= mem[mem_ra];
    if (root_we) root_q[root_wa] <= root_wd;
    root_rd_q <= root_q[ridx];
    if (state_q == S_IDLE && in_valid_i) req_q <= in_data_i;
    if (tlb_fill) begin
      tlb_tag_q[ti] <= vpn;
      tlb_fr_q[ti]  <= req_q.phys_frame;
    end
    lvl_q <= lvl_d;
    tf_q  <= tf_d;
    zc_q  <= zc_d;
    nf_q  <= nf_d;
    rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      tlb_v_q  <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (tlb_fill) tlb_v_q[ti] <= 1'b1;
      else if (tlb_drop) tlb_v_q[ti] <= 1'b0;
    end
  end

  // A response is presented only from the response state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("response shown while idle");

  // A stalled response holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled response changed");

  // A TLB hit is reported only for translate.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.tlb_hit |-> req_q.opcode == OP_TRANSLATE)
    else $error("tlb hit on non-translate");

endmodule

### tb/four_level_page_walk_tlb_unit_test.sv
`timescale 1ns / 1ps
module four_level_page_walk_tlb_unit_test;
  import fpw_pkg::*;

  localparam int NFR = 64;
  localparam int NTLB = 16;
  localparam int WATCHDOG_LIMIT = 30000;
  localparam int RANDOM_ITEMS = 500;
  localparam int N_DIR = 18;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  req_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_data_o;

  four_level_page_walk_tlb_unit dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the translation state.
  logic [ENTRY_W-1:0] root_shadow [TABLE_ENTRIES];
  logic [ENTRY_W-1:0] table_shadow [NFR*TABLE_ENTRIES];
  logic               frame_busy [NFR];
  logic               tlb_v [NTLB];
  logic [VPN_W-1:0]   tlb_vpn [NTLB];
  logic [FRAME_W-1:0] tlb_pfn [NTLB];

  rsp_t expected_rsp [$];
  int   errors = 0;
  int   items_in = 0;
  int   rsp_seen = 0;
  int   hits_seen = 0;
  int   noframe_seen = 0;
  int   send_pct = 100;
  int   stall_pct = 0;
  bit   stim_done = 0;

  typedef struct {
    logic [1:0]  op;
    logic [47:0] va;
    logic [5:0]  pf;
    bit          fixed;
    rsp_t        rsp;
  } dir_row_t;

  dir_row_t dir_rows [N_DIR];

  function automatic int entry_addr(int tf, int lvl, logic [47:0] va);
    return tf * TABLE_ENTRIES + int'(va[PAGE_SHIFT + IDX_W*lvl +: IDX_W]);
  endfunction

  function automatic logic [ENTRY_W-1:0] read_entry(int tf, int lvl, logic [47:0] va);
    if (lvl == 3) return root_shadow[va[47:39]];
    return table_shadow[entry_addr(tf, lvl, va)];
  endfunction

  function automatic void write_entry(int tf, int lvl, logic [47:0] va,
                                      logic [ENTRY_W-1:0] e);
    if (lvl == 3) root_shadow[va[47:39]] = e;
    else table_shadow[entry_addr(tf, lvl, va)] = e;
  endfunction

  function automatic int lowest_free();
    for (int i = 0; i < NFR; i++) if (!frame_busy[i]) return i;
    return -1;
  endfunction

  // Walks the upper levels; returns the leaf table frame or -1.
  function automatic int leaf_table(logic [47:0] va);
    logic [ENTRY_W-1:0] e;
    int tf;
    tf = 0;
    for (int lvl = 3; lvl > 0; lvl--) begin
      e = read_entry(tf, lvl, va);
      if (!e[0]) return -1;
      tf = int'(e[6:1]);
    end
    return tf;
  endfunction

  // Computes the response for one request and updates the shadow state.
  function automatic rsp_t mmu_predict(req_t rq);
    rsp_t r;
    logic [VPN_W-1:0] vpn;
    int ti, tf, f, lt;
    bit failed;
    logic [ENTRY_W-1:0] e;
    r = '0;
    vpn = rq.virt_addr[47:12];
    ti = int'(vpn % NTLB);
    case (rq.opcode)
      OP_TRANSLATE: begin
        if (tlb_v[ti] && tlb_vpn[ti] == vpn) begin
          r.tlb_hit = 1'b1; r.present = 1'b1; r.frame_out = tlb_pfn[ti];
        end else begin
          lt = leaf_table(rq.virt_addr);
          e = (lt < 0) ? '0 : read_entry(lt, 0, rq.virt_addr);
          if (e[0]) begin
            r.present = 1'b1; r.frame_out = e[6:1];
          end else r.status = ST_UNMAPPED;
        end
      end
      OP_MAP: begin
        tf = 0; failed = 0;
        for (int lvl = 3; lvl > 0 && !failed; lvl--) begin
          e = read_entry(tf, lvl, rq.virt_addr);
          if (!e[0]) begin
            f = lowest_free();
            if (f < 0) failed = 1;
            else begin
              frame_busy[f] = 1'b1;
              for (int k = 0; k < TABLE_ENTRIES; k++) table_shadow[f*TABLE_ENTRIES + k] = '0;
              e = {f[5:0], 1'b1};
              write_entry(tf, lvl, rq.virt_addr, e);
            end
          end
          if (!failed) tf = int'(e[6:1]);
        end
        if (failed) r.status = ST_NOFRAME;
        else begin
          write_entry(tf, 0, rq.virt_addr, {rq.phys_frame, 1'b1});
          tlb_v[ti] = 1'b1; tlb_vpn[ti] = vpn; tlb_pfn[ti] = rq.phys_frame;
          r.present = 1'b1; r.frame_out = rq.phys_frame;
        end
      end
      OP_ALLOC: begin
        f = lowest_free();
        if (f < 0) r.status = ST_NOFRAME;
        else begin
          frame_busy[f] = 1'b1; r.frame_out = f[5:0];
        end
      end
      default: begin
        lt = leaf_table(rq.virt_addr);
        e = (lt < 0) ? '0 : read_entry(lt, 0, rq.virt_addr);
        if (e[0]) begin
          r.frame_out = e[6:1];
          frame_busy[e[6:1]] = 1'b0;
          write_entry(lt, 0, rq.virt_addr, '0);
        end else r.status = ST_UNMAPPED;
        if (tlb_v[ti] && tlb_vpn[ti] == vpn) tlb_v[ti] = 1'b0;
      end
    endcase
    return r;
  endfunction

  // Addresses mostly share a few table paths so that walks go deep.
  function automatic logic [47:0] pick_va();
    logic [47:0] va;
    if ($urandom_range(0, 9) == 0) return 48'({$urandom, $urandom});
    va[47:39] = $urandom_range(0, 1) ? 9'd511 : 9'd0;
    va[38:30] = $urandom_range(0, 1) ? 9'd3 : 9'd0;
    va[29:21] = $urandom_range(0, 1) ? 9'd7 : 9'd0;
    va[20:12] = 9'($urandom_range(0, 3)) | ($urandom_range(0, 7) == 0 ? 9'h1f0 : 9'h0);
    va[11:0]  = 12'($urandom);
    return va;
  endfunction

  function automatic logic [1:0] pick_op();
    int p;
    p = $urandom_range(0, 99);
    if (p < 35) return OP_TRANSLATE;
    if (p < 65) return OP_MAP;
    if (p < 75) return OP_ALLOC;
    return OP_UNMAP;
  endfunction

  task automatic report_mismatch(string what, rsp_t got, rsp_t want);
    errors++;
    $display("mismatch on %s at %0t: got %0d/%0d/%0d/%0d want %0d/%0d/%0d/%0d", what, $time,
             got.status, got.tlb_hit, got.present, got.frame_out,
             want.status, want.tlb_hit, want.present, want.frame_out);
  endtask

  function automatic dir_row_t mk(logic [1:0] op, logic [47:0] va, logic [5:0] pf,
                                  bit fixed, rsp_t rsp);
    dir_row_t d;
    d.op = op; d.va = va; d.pf = pf; d.fixed = fixed; d.rsp = rsp;
    return d;
  endfunction

  initial begin
    rsp_t nm, nz;
    nm = '{status: ST_UNMAPPED, tlb_hit: 1'b0, present: 1'b0, frame_out: '0};
    nz = '0;
    dir_rows[0]  = mk(OP_TRANSLATE, 48'h0, 6'd0, 1, nm);
    dir_rows[1]  = mk(OP_UNMAP, 48'hffff_ffff_ffff, 6'd0, 1, nm);
    dir_rows[2]  = mk(OP_ALLOC, 48'h0, 6'd0, 1,
                      '{status: ST_OK, tlb_hit: 1'b0, present: 1'b0, frame_out: 6'd0});
    dir_rows[3]  = mk(OP_MAP, 48'h0, 6'd63, 0, nz);
    dir_rows[4]  = mk(OP_TRANSLATE, 48'h0000_0000_0fff, 6'd0, 1,
                      '{status: ST_OK, tlb_hit: 1'b1, present: 1'b1, frame_out: 6'd63});
    dir_rows[5]  = mk(OP_MAP, 48'hffff_ffff_ffff, 6'd0, 0, nz);
    dir_rows[6]  = mk(OP_TRANSLATE, 48'hffff_ffff_f000, 6'd0, 0, nz);
    // Same TLB slot, different page: forces a walk.
    dir_rows[7]  = mk(OP_MAP, 48'h0000_0001_0000, 6'd21, 0, nz);
    dir_rows[8]  = mk(OP_TRANSLATE, 48'h0, 6'd0, 0, nz);
    // Present leaf overwritten.
    dir_rows[9]  = mk(OP_MAP, 48'h0, 6'd42, 0, nz);
    dir_rows[10] = mk(OP_TRANSLATE, 48'h0, 6'd0, 0, nz);
    dir_rows[11] = mk(OP_UNMAP, 48'h0, 6'd0, 0, nz);
    dir_rows[12] = mk(OP_TRANSLATE, 48'h0, 6'd0, 1, nm);
    dir_rows[13] = mk(OP_UNMAP, 48'h0, 6'd0, 1, nm);
    dir_rows[14] = mk(OP_ALLOC, 48'hffff_ffff_ffff, 6'd63, 0, nz);
    // Unmap of a leaf pointing at a table frame frees that frame.
    dir_rows[15] = mk(OP_MAP, 48'h0000_0000_2000, 6'd1, 0, nz);
    dir_rows[16] = mk(OP_UNMAP, 48'h0000_0000_2000, 6'd0, 0, nz);
    dir_rows[17] = mk(OP_ALLOC, 48'h0, 6'd0, 0, nz);
  end

  // Sender: offers items, records each accepted one with its expectation.
  initial begin
    int sent;
    req_t rq;
    rsp_t pr;
    for (int i = 0; i < TABLE_ENTRIES; i++) root_shadow[i] = '0;
    for (int i = 0; i < NFR*TABLE_ENTRIES; i++) table_shadow[i] = '0;
    for (int i = 0; i < NFR; i++) frame_busy[i] = 1'b0;
    for (int i = 0; i < NTLB; i++) begin
      tlb_v[i] = 1'b0; tlb_vpn[i] = '0; tlb_pfn[i] = '0;
    end
    sent = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (!stim_done) begin
      @(posedge clk_i);
      if (in_valid_i && !in_stall_o) begin
        pr = mmu_predict(in_data_i);
        if (items_in < N_DIR && dir_rows[items_in].fixed) expected_rsp.push_back(dir_rows[items_in].rsp);
        else expected_rsp.push_back(pr);
        items_in++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (sent >= N_DIR + RANDOM_ITEMS) begin
          in_valid_i <= 1'b0;
          if (items_in == sent) stim_done = 1;
        end else if (sent >= N_DIR && $urandom_range(1, 100) > send_pct) begin
          in_valid_i <= 1'b0;
        end else begin
          if (sent < N_DIR) begin
            rq.opcode = dir_rows[sent].op;
            rq.virt_addr = dir_rows[sent].va;
            rq.phys_frame = dir_rows[sent].pf;
          end else begin
            rq.opcode = pick_op();
            rq.virt_addr = pick_va();
            rq.phys_frame = 6'($urandom);
          end
          in_data_i <= rq;
          in_valid_i <= 1'b1;
          sent++;
        end
        // Idling phases over the random part.
        if (sent > N_DIR) begin
          case (((sent - N_DIR) / 125) % 4)
            0: begin send_pct = 100; stall_pct = 0; end
            1: begin send_pct = 51; stall_pct = 0; end
            2: begin send_pct = 100; stall_pct = 49; end
            default: begin send_pct = 67; stall_pct = 33; end
          endcase
        end
      end
    end
  end

  // Receiver: random stalls, one long hold-off, response check, watchdog.
  int hold_left = 0;
  bit hold_used = 0;
  int quiet = 0;
  rsp_t want;
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (expected_rsp.size() == 0) begin
        errors++;
        $display("unexpected response at %0t", $time);
      end else begin
        want = expected_rsp.pop_front();
        if (out_data_o.status !== want.status) report_mismatch("status", out_data_o, want);
        if (out_data_o.tlb_hit !== want.tlb_hit) report_mismatch("tlb_hit", out_data_o, want);
        if (out_data_o.present !== want.present) report_mismatch("present", out_data_o, want);
        if (out_data_o.frame_out !== want.frame_out)
          report_mismatch("frame_out", out_data_o, want);
        if (want.tlb_hit) hits_seen++;
        if (want.status == ST_NOFRAME) noframe_seen++;
      end
      rsp_seen++;
    end
    if (!hold_used && rsp_seen >= 60) begin
      hold_used = 1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else out_stall_i <= ($urandom_range(1, 100) <= stall_pct);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("four_level_page_walk_tlb_unit_test: errors");
      $finish;
    end
  end

  // End of run.
  initial begin
    wait (stim_done);
    wait (expected_rsp.size() == 0);
    repeat (50) @(posedge clk_i);
    $display("run covered %0d requests, %0d responses, %0d TLB hits, %0d out-of-frame answers",
             items_in, rsp_seen, hits_seen, noframe_seen);
    $display("with translate, map, alloc and unmap under sender gaps and receiver stalls");
    if (errors == 0) begin
      $display("four_level_page_walk_tlb_unit_test: clean");
    end else begin
      $display("four_level_page_walk_tlb_unit_test: errors");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/fpw_pkg.sv
rtl/fpw_alloc.sv
rtl/four_level_page_walk_tlb_unit.sv
tb/four_level_page_walk_tlb_unit_test.sv
